@@ design/histogram_equalizer_rgb_luma_core_macros.svh @@
// assertion macros for the histogram equalizer core
// no dependencies; included by the top level only
`ifndef HISTOGRAM_EQUALIZER_RGB_LUMA_CORE_MACROS_SVH
`define HISTOGRAM_EQUALIZER_RGB_LUMA_CORE_MACROS_SVH
`ifndef SYNTH
`define HEQ_ASSERT_SAME(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define HEQ_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define HEQ_ASSERT_SAME(lbl, clk, rst_n, a, c)
`define HEQ_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

@@ design/heq_pkg.sv @@
// shared types, constants and controller codes for the histogram equalizer
// no dependencies
`timescale 1ns / 1ps
package heq_pkg;

  localparam int MAX_PIXELS = 1048576;
  localparam int NBINS      = 256;
  localparam int BIN_W      = 8;
  localparam int LANES      = 4;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int CUM_W      = CNT_W + BIN_W;
  localparam int NUM_W      = CUM_W + BIN_W;
  localparam int DIV_STEPS  = BIN_W + 1;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // lane indexes
  localparam int LN_Y = 0;
  localparam int LN_R = 1;
  localparam int LN_G = 2;
  localparam int LN_B = 3;

  // q16 coefficients
  localparam int KYR = 19595;
  localparam int KYG = 38470;
  localparam int KYB = 7471;
  localparam int KUR = 9634;
  localparam int KUG = 18940;
  localparam int KUB = 28508;
  localparam int KVR = 40305;
  localparam int KVG = 33751;
  localparam int KVB = 6554;
  localparam int KRV = 92242;
  localparam int KGU = 22643;
  localparam int KGV = 46983;
  localparam int KBU = 116589;

  typedef struct packed {
    logic       req_type;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } in_data_t;

  typedef struct packed {
    logic [7:0] gray_eq;
    logic [7:0] red_eq;
    logic [7:0] green_eq;
    logic [7:0] blue_eq;
    logic [7:0] red_from_luma;
    logic [7:0] green_from_luma;
    logic [7:0] blue_from_luma;
    logic       end_of_frame;
  } out_data_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CALC, ST_RD, ST_UPD, ST_MUL, ST_OUT,
    ST_B_RD, ST_B_ACC, ST_B_NUM, ST_B_DIV, ST_B_WR, ST_B_END,
    ST_CLR
  } state_t;

  typedef struct packed {
    logic clr;
    logic cap_pix;
    logic calc;
    logic rd;
    logic upd;
    logic mul;
    logic load_out;
    logic b_rd;
    logic b_acc;
    logic b_num;
    logic b_div;
    logic b_wr;
    logic b_end;
  } cmd_t;

  typedef struct packed {
    logic is_map;
    logic is_last;
    logic out_busy;
    logic div_done;
    logic idx_last;
  } sts_t;

endpackage

@@ design/heq_ctrl.sv @@
// controller state machine for the histogram equalizer
// depends on heq_pkg
`timescale 1ns / 1ps
module heq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  heq_pkg::sts_t sts,
  output heq_pkg::cmd_t cmd
);
  import heq_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLR: begin
        // zero every histogram bin once after reset
        cmd.clr = 1'b1;
        if (sts.idx_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_pix = 1'b1;
          state_nxt   = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = sts.is_map ? ST_MUL : ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.is_last ? ST_B_RD : ST_IDLE;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output slot to free up
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_B_RD: begin
        cmd.b_rd  = 1'b1;
        state_nxt = ST_B_ACC;
      end
      ST_B_ACC: begin
        cmd.b_acc = 1'b1;
        state_nxt = ST_B_NUM;
      end
      ST_B_NUM: begin
        cmd.b_num = 1'b1;
        state_nxt = ST_B_DIV;
      end
      ST_B_DIV: begin
        cmd.b_div = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_B_WR;
        end
      end
      ST_B_WR: begin
        cmd.b_wr  = 1'b1;
        state_nxt = sts.idx_last ? ST_B_END : ST_B_RD;
      end
      ST_B_END: begin
        cmd.b_end = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/heq_dp.sv @@
// datapath: color transform, histograms, map tables, divider, output register
// depends on heq_pkg
`timescale 1ns / 1ps
module heq_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  heq_pkg::in_data_t    in_data,
  input  heq_pkg::cmd_t        cmd,
  output heq_pkg::sts_t        sts,
  output heq_pkg::out_data_t   out_data,
  output logic                 out_valid,
  input  logic                 out_ready
);
  import heq_pkg::*;

  localparam int Y_W  = 24;
  localparam int UV_W = 25;
  localparam int P_W  = 44;
  localparam int S_W  = 45;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    if (c >= CNT_W'(MAX_PIXELS)) begin
      return CNT_W'(MAX_PIXELS);
    end
    return c + 1'b1;
  endfunction

  function automatic logic [7:0] clamp_q32(input logic signed [S_W-1:0] v);
    if (v <= 0) begin
      return 8'd0;
    end
    if (v >= $signed({1'b0, 8'd255, 32'd0})) begin
      return 8'd255;
    end
    return v[39:32];
  endfunction

  // pixel and transform registers
  in_data_t                pix_r;
  logic [Y_W-1:0]          yq_r;
  logic signed [UV_W-1:0]  uq_r, vq_r;
  logic [BIN_W-1:0]        addr [LANES];

  // histogram and map storage
  logic [CNT_W-1:0] cnt_mem [LANES][NBINS];
  logic [BIN_W-1:0] map_mem [LANES][NBINS];
  logic [CNT_W-1:0] cnt_rd_r [LANES];
  logic [BIN_W-1:0] map_rd_r [LANES];
  logic             built_r;
  logic [CNT_W-1:0] total_r;

  // build sweep
  logic [BIN_W-1:0]  idx_r;
  logic [CUM_W-1:0]  cum_r [LANES];
  logic [NUM_W-1:0]  rem_r [LANES];
  logic [DIV_STEPS-1:0] q_r [LANES];
  logic [NUM_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;

  // inverse transform products
  logic signed [P_W-1:0] p_rv_r, p_gu_r, p_gv_r, p_bu_r;
  logic [BIN_W-1:0]      yeq;
  logic signed [S_W-1:0] y32, rr, gg, bb;

  out_data_t out_r;
  logic      out_valid_r;

  // lane addresses: pixel bins, or the sweep index during a build
  always_comb begin
    if (cmd.b_rd) begin
      for (int l = 0; l < LANES; l++) begin
        addr[l] = idx_r;
      end
    end else begin
      addr[LN_Y] = yq_r[Y_W-1:Y_W-BIN_W];
      addr[LN_R] = pix_r.red;
      addr[LN_G] = pix_r.green;
      addr[LN_B] = pix_r.blue;
    end
  end

  // capture pixel and forward transform
  always_ff @(posedge clk) begin
    if (cmd.cap_pix) begin
      pix_r <= in_data;
    end
    if (cmd.calc) begin
      yq_r <= Y_W'(KYR) * Y_W'(pix_r.red) + Y_W'(KYG) * Y_W'(pix_r.green)
            + Y_W'(KYB) * Y_W'(pix_r.blue);
      uq_r <= $signed(UV_W'(KUB) * UV_W'(pix_r.blue) - UV_W'(KUR) * UV_W'(pix_r.red)
            - UV_W'(KUG) * UV_W'(pix_r.green));
      vq_r <= $signed(UV_W'(KVR) * UV_W'(pix_r.red) - UV_W'(KVG) * UV_W'(pix_r.green)
            - UV_W'(KVB) * UV_W'(pix_r.blue));
    end
  end

  // memory reads
  always_ff @(posedge clk) begin
    if (cmd.rd || cmd.b_rd) begin
      for (int l = 0; l < LANES; l++) begin
        cnt_rd_r[l] <= cnt_mem[l][addr[l]];
        map_rd_r[l] <= map_mem[l][addr[l]];
      end
    end
  end

  // histogram writes: count update, or zero at the sweep index while clearing or on a build write
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (cmd.upd) begin
        cnt_mem[l][addr[l]] <= sat_inc(cnt_rd_r[l]);
      end else if (cmd.clr || cmd.b_wr) begin
        cnt_mem[l][idx_r] <= '0;
      end
    end
  end

  // map writes at the sweep index
  always_ff @(posedge clk) begin
    if (cmd.b_wr) begin
      for (int l = 0; l < LANES; l++) begin
        if (total_r == '0) begin
          map_mem[l][idx_r] <= '0;
        end else if (q_r[l][DIV_STEPS-1]) begin
          map_mem[l][idx_r] <= '1;
        end else begin
          map_mem[l][idx_r] <= q_r[l][BIN_W-1:0];
        end
      end
    end
  end

  // pixel total, sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LANES; l++) begin
        cum_r[l] <= '0;
      end
      built_r <= 1'b0;
      total_r <= '0;
      idx_r   <= '0;
      step_r  <= '0;
    end else begin
      if (cmd.upd) begin
        total_r <= sat_inc(total_r);
      end
      if (cmd.b_acc) begin
        for (int l = 0; l < LANES; l++) begin
          cum_r[l] <= cum_r[l] + CUM_W'(cnt_rd_r[l]);
        end
      end
      if (cmd.b_num) begin
        step_r <= '0;
      end
      if (cmd.b_div) begin
        step_r <= step_r + 1'b1;
      end
      if (cmd.b_wr || cmd.clr) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.b_end) begin
        for (int l = 0; l < LANES; l++) begin
          cum_r[l] <= '0;
        end
        built_r <= 1'b1;
        total_r <= '0;
      end
    end
  end

  // restoring divider, one quotient bit per cycle in each lane
  always_ff @(posedge clk) begin
    if (cmd.b_num) begin
      den_r <= NUM_W'(total_r) << BIN_W;
      for (int l = 0; l < LANES; l++) begin
        rem_r[l] <= (NUM_W'(cum_r[l]) << BIN_W) - NUM_W'(cum_r[l]);
        q_r[l]   <= '0;
      end
    end else if (cmd.b_div) begin
      den_r <= den_r >> 1;
      for (int l = 0; l < LANES; l++) begin
        if (rem_r[l] >= den_r) begin
          rem_r[l] <= rem_r[l] - den_r;
          q_r[l]   <= {q_r[l][DIV_STEPS-2:0], 1'b1};
        end else begin
          q_r[l]   <= {q_r[l][DIV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  // inverse transform products
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_rv_r <= P_W'(vq_r) * P_W'(KRV);
      p_gu_r <= P_W'(uq_r) * P_W'(KGU);
      p_gv_r <= P_W'(vq_r) * P_W'(KGV);
      p_bu_r <= P_W'(uq_r) * P_W'(KBU);
    end
  end

  // sums and clamps
  always_comb begin
    yeq = built_r ? map_rd_r[LN_Y] : '0;
    y32 = $signed({5'd0, yeq, 32'd0});
    rr  = y32 + S_W'(p_rv_r);
    gg  = y32 - S_W'(p_gu_r) - S_W'(p_gv_r);
    bb  = y32 + S_W'(p_bu_r);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.gray_eq         <= yeq;
      out_r.red_eq          <= built_r ? map_rd_r[LN_R] : '0;
      out_r.green_eq        <= built_r ? map_rd_r[LN_G] : '0;
      out_r.blue_eq         <= built_r ? map_rd_r[LN_B] : '0;
      out_r.red_from_luma   <= clamp_q32(rr);
      out_r.green_from_luma <= clamp_q32(gg);
      out_r.blue_from_luma  <= clamp_q32(bb);
      out_r.end_of_frame    <= pix_r.last;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  // status to the controller
  assign sts.is_map   = pix_r.req_type;
  assign sts.is_last  = pix_r.last;
  assign sts.out_busy = out_valid_r && !out_ready;
  assign sts.div_done = (step_r == STEP_W'(DIV_STEPS - 1));
  assign sts.idx_last = (idx_r == '1);

endmodule

@@ design/histogram_equalizer_rgb_luma_core.sv @@
// top level of the histogram equalizer: controller plus datapath
// depends on heq_pkg, heq_ctrl, heq_dp and the assertion macro header
`timescale 1ns / 1ps
// Usage:
//   in_*  : pixel requests, valid/ready. req_type 0 counts the pixel into the
//           luma, red, green and blue histograms; req_type 1 maps it.
//   out_* : one result per map request, valid/ready, from an output register.
//   Count request: after acceptance the core runs the transform, the histogram
//   read and the read-modify-write of the bins before it accepts again.
//   Map request: transform, map read, product stage, then sum and clamp into
//   the output register once it is free; then the next request is accepted.
//   A count request with last set starts the map build over all 256 bins,
//   each by read, accumulate, scale, 9-step restoring divide and write, plus
//   a closing step; in_ready is low throughout.
//   The sweep also zeroes each bin.
//   Reset: a clearing pass zeroes all 256 histogram bins with in_ready
//   low; maps read as zero through a built flag until the first build.
//   Receiver stall: a finished result waits in the output register while
//   the next request is accepted; a second map result waits in the
//   controller until the register frees up.
module histogram_equalizer_rgb_luma_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  heq_pkg::in_data_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output heq_pkg::out_data_t   out_data
);
  import heq_pkg::*;
`include "histogram_equalizer_rgb_luma_core_macros.svh"

  cmd_t cmd;
  sts_t sts;

  heq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  heq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  // checks on the controller and datapath
  `HEQ_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
  `HEQ_ASSERT_SAME(a_load_slot_free, clk, rst_n, cmd.load_out, !out_valid || out_ready)
  `HEQ_ASSERT_SAME(a_build_blocks_in, clk, rst_n, cmd.b_div || cmd.b_wr, !in_ready)
  `HEQ_ASSERT_NEXT(a_build_end_idle, clk, rst_n, cmd.b_end, in_ready)

endmodule

@@ verif/tb_histogram_equalizer_rgb_luma_core.sv @@
// testbench for the histogram equalizer core: random count/map pixel streams
// checked against a built-in predictor; depends on heq_pkg and the core
`timescale 1ns / 1ps
module tb_histogram_equalizer_rgb_luma_core;
  import heq_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_data_t in_data;
  logic out_valid;
  logic out_ready;
  out_data_t out_data;

  histogram_equalizer_rgb_luma_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // predictor state
  int unsigned hist_cnt [LANES][NBINS];
  logic [7:0] eq_map [LANES][NBINS] = '{default: '0};
  int unsigned pix_total;

  in_data_t pending_px[$];
  out_data_t expected_px[$];
  int errors;
  bit stim_done;

  function automatic int unsigned bump(int unsigned c);
    return (c >= MAX_PIXELS) ? MAX_PIXELS : c + 1;
  endfunction

  function automatic logic [7:0] clamp_q32(longint v);
    if (v <= 0) return 8'd0;
    if (v >= 64'sd255 * (64'sd1 <<< 32)) return 8'd255;
    return v[39:32];
  endfunction

  // apply one accepted request to the predictor
  task automatic predict_pixel(in_data_t px);
    longint r, g, b, yq, uq, vq, y32, cum, v;
    int ybin;
    out_data_t o;
    r = px.red; g = px.green; b = px.blue;
    yq = KYR * r + KYG * g + KYB * b;
    uq = -KUR * r - KUG * g + KUB * b;
    vq = KVR * r - KVG * g - KVB * b;
    ybin = int'(yq >>> 16);
    if (ybin > 255) ybin = 255;
    if (!px.req_type) begin
      hist_cnt[LN_Y][ybin] = bump(hist_cnt[LN_Y][ybin]);
      hist_cnt[LN_R][r] = bump(hist_cnt[LN_R][r]);
      hist_cnt[LN_G][g] = bump(hist_cnt[LN_G][g]);
      hist_cnt[LN_B][b] = bump(hist_cnt[LN_B][b]);
      pix_total = bump(pix_total);
      if (px.last) begin
        for (int ln = 0; ln < LANES; ln++) begin
          cum = 0;
          for (int i = 0; i < NBINS; i++) begin
            cum += hist_cnt[ln][i];
            v = (pix_total == 0) ? 0 : (cum * 255) / pix_total;
            eq_map[ln][i] = (v > 255) ? 8'd255 : v[7:0];
            hist_cnt[ln][i] = 0;
          end
        end
        pix_total = 0;
      end
    end else begin
      o.gray_eq = eq_map[LN_Y][ybin];
      o.red_eq = eq_map[LN_R][r];
      o.green_eq = eq_map[LN_G][g];
      o.blue_eq = eq_map[LN_B][b];
      y32 = longint'(o.gray_eq) <<< 32;
      o.red_from_luma = clamp_q32(y32 + KRV * vq);
      o.green_from_luma = clamp_q32(y32 - KGU * uq - KGV * vq);
      o.blue_from_luma = clamp_q32(y32 + KBU * uq);
      o.end_of_frame = px.last;
      expected_px.push_back(o);
    end
  endtask

  function automatic in_data_t make_px(bit map, int r, int g, int b, bit lst);
    in_data_t p;
    p.req_type = map; p.red = 8'(r); p.green = 8'(g); p.blue = 8'(b); p.last = lst;
    return p;
  endfunction

  // a frame: count pixels then map pixels, mostly small, last on both ends
  task automatic queue_frame(int n_cnt, int n_map);
    for (int i = 0; i < n_cnt; i++)
      pending_px.push_back(make_px(1'b0, $urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255), i == n_cnt - 1));
    for (int i = 0; i < n_map; i++)
      pending_px.push_back(make_px(1'b1, $urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255), i == n_map - 1));
  endtask

  // stimulus
  initial begin
    // map before any build uses zero maps
    pending_px.push_back(make_px(1'b1, 255, 255, 255, 1'b1));
    pending_px.push_back(make_px(1'b1, 0, 0, 0, 1'b0));
    // single-pixel frame at the extremes
    pending_px.push_back(make_px(1'b0, 255, 255, 255, 1'b1));
    pending_px.push_back(make_px(1'b1, 255, 0, 255, 1'b0));
    pending_px.push_back(make_px(1'b1, 0, 255, 0, 1'b1));
    // small frame with interleaved count and map pixels
    pending_px.push_back(make_px(1'b0, 0, 0, 0, 1'b0));
    pending_px.push_back(make_px(1'b1, 255, 255, 0, 1'b0));
    pending_px.push_back(make_px(1'b0, 0, 0, 0, 1'b0));
    pending_px.push_back(make_px(1'b0, 128, 64, 200, 1'b0));
    pending_px.push_back(make_px(1'b0, 255, 0, 0, 1'b1));
    pending_px.push_back(make_px(1'b1, 0, 0, 0, 1'b0));
    pending_px.push_back(make_px(1'b1, 255, 0, 0, 1'b0));
    pending_px.push_back(make_px(1'b1, 0, 0, 255, 1'b0));
    pending_px.push_back(make_px(1'b1, 128, 64, 200, 1'b1));
    // random frames
    while (pending_px.size() < 900) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: loose map pixels
        pending_px.push_back(make_px(1'b1, $urandom_range(0, 255), $urandom_range(0, 255),
                                     $urandom_range(0, 255), $urandom_range(0, 1)));
      end else begin
        queue_frame($urandom_range(1, 60), $urandom_range(1, 40));
      end
    end
  end

  // driver: bursts and gaps; one pause until drained midway
  int burst_left;
  int gap_left;
  int n_sent;
  bit drain_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
      n_sent <= 0;
      stim_done <= 1'b0;
      drain_done <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) n_sent <= n_sent + 1;
      if (pending_px.size() == 0) begin
        in_valid <= 1'b0;
        stim_done <= 1'b1;
      end else if (!drain_done && n_sent >= 450) begin
        // drain pause: wait until every result has come
        in_valid <= 1'b0;
        if (!in_valid && expected_px.size() == 0) drain_done <= 1'b1;
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else begin
        in_valid <= 1'b1;
        in_data <= pending_px.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // accepted requests feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_pixel(in_data);
  end

  // receiver stall pattern with one long hold-off while a map request waits
  int rx_cycle;
  int hold_left;
  bit hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_cycle <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && rx_cycle > 3000 && out_valid && in_valid &&
                   in_data.req_type) begin
        hold_left <= 400;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else if ((rx_cycle / 500) % 3 == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    out_data_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      if (expected_px.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        exp_px = expected_px.pop_front();
        if (out_data.gray_eq !== exp_px.gray_eq) begin
          $error("gray_eq exp %0d got %0d", exp_px.gray_eq, out_data.gray_eq); errors++;
        end
        if (out_data.red_eq !== exp_px.red_eq) begin
          $error("red_eq exp %0d got %0d", exp_px.red_eq, out_data.red_eq); errors++;
        end
        if (out_data.green_eq !== exp_px.green_eq) begin
          $error("green_eq exp %0d got %0d", exp_px.green_eq, out_data.green_eq); errors++;
        end
        if (out_data.blue_eq !== exp_px.blue_eq) begin
          $error("blue_eq exp %0d got %0d", exp_px.blue_eq, out_data.blue_eq); errors++;
        end
        if (out_data.red_from_luma !== exp_px.red_from_luma) begin
          $error("red_from_luma exp %0d got %0d", exp_px.red_from_luma,
                 out_data.red_from_luma); errors++;
        end
        if (out_data.green_from_luma !== exp_px.green_from_luma) begin
          $error("green_from_luma exp %0d got %0d", exp_px.green_from_luma,
                 out_data.green_from_luma); errors++;
        end
        if (out_data.blue_from_luma !== exp_px.blue_from_luma) begin
          $error("blue_from_luma exp %0d got %0d", exp_px.blue_from_luma,
                 out_data.blue_from_luma); errors++;
        end
        if (out_data.end_of_frame !== exp_px.end_of_frame) begin
          $error("end_of_frame exp %0d got %0d", exp_px.end_of_frame,
                 out_data.end_of_frame); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or delivered result
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // reset, then wait for the end of stimulus and the drain
  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && expected_px.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_px.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
